// ----- sv/ptk_pkg.sv -----
// shared types, constants and helpers for the per-pixel top-k accuracy block
// no dependencies; used by ptk_cell, ptk_div and per_pixel_topk_accuracy_top
`default_nettype none

package ptk_pkg;

   localparam int SCORE_W    = 16;
   localparam int LABEL_W    = 8;
   localparam int TOTAL_W    = 32;
   localparam int ACC_W      = 17;
   localparam int KREG_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_K_BEST        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE_VALUE  = 2'd2;

   localparam logic [KREG_W-1:0]  K_BEST_RESET       = 4'd1;
   localparam logic [LABEL_W-1:0] IGNORE_VALUE_RESET = 8'd255;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [LABEL_W-1:0]        true_label;
      logic                      last_channel;
      logic                      last_pixel;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] hits;
      logic [TOTAL_W-1:0] counted_pixels;
      logic [TOTAL_W-1:0] skipped_pixels;
      logic [ACC_W-1:0]   accuracy_q16;
      logic               empty_frame;
   } rsp_type;

   // frame totals handed to the divider
   typedef struct packed {
      logic [TOTAL_W-1:0] hits;
      logic [TOTAL_W-1:0] pixels;
      logic [TOTAL_W-1:0] skips;
   } ptk_totals_type;

   // per-cell control from the list controller
   typedef struct packed {
      logic ins;    // a score is being inserted this cycle
      logic occ;    // cell holds a live entry
      logic avail;  // cell index is below the effective k
   } ptk_cell_ctl_type;

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      return (v == '1) ? v : v + TOTAL_W'(1);
   endfunction

endpackage

`default_nettype wire

// ----- sv/per_pixel_topk_accuracy_top.sv -----
// Per-pixel top-k accuracy. Scores stream in one channel per transaction; a chain
// of MAX_K cells keeps the pixel's best scores sorted and takes one transaction per
// cycle while req_stall is low, each insertion ranked combinationally across the
// chain and registered in its cells. The pixel is scored in a registered finish
// stage after its last channel, overlapping the next pixel's first channel. At a
// frame's last pixel the totals go to a restoring divider that finds one quotient
// bit per cycle (none when no pixel was counted) and then holds the result until
// the rsp transaction completes; the totals of the next frame collect in the
// meantime. req_stall rises only when a frame's last pixel finishes while the
// previous frame's result is still in the divider or not yet taken. Csr writes are
// accepted every cycle. No clearing pass is needed after reset.
// depends on ptk_pkg, ptk_cell, ptk_div
`default_nettype none

module per_pixel_topk_accuracy_top #(
   parameter int MAX_K        = 8,
   parameter int MAX_CHANNELS = 256
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire ptk_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output ptk_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ptk_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ptk_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FILL_W = $clog2(MAX_K + 1);
   localparam int KC_W   = (FILL_W > ptk_pkg::KREG_W) ? FILL_W : ptk_pkg::KREG_W;
   localparam int CH_W   = $clog2(MAX_CHANNELS);
   localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
   localparam int CMP_W  = (CH_W > ptk_pkg::LABEL_W) ? CH_W : ptk_pkg::LABEL_W;
   localparam int TW     = ptk_pkg::TOTAL_W;

   // configuration registers
   logic [ptk_pkg::KREG_W-1:0]  k_ff, k_in;
   logic                        ign_en_ff, ign_en_in;
   logic [ptk_pkg::LABEL_W-1:0] ign_val_ff, ign_val_in;

   // list and pixel control
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [CNT_W-1:0]            chan_cnt_ff, chan_cnt_in;
   logic                        pend_ff, pend_in;
   logic                        pend_last_ff, pend_last_in;
   logic                        pend_skip_ff, pend_skip_in;
   logic [ptk_pkg::LABEL_W-1:0] pend_label_ff, pend_label_in;

   logic [TW-1:0] hit_ff, hit_in;
   logic [TW-1:0] pix_ff, pix_in;
   logic [TW-1:0] skip_ff, skip_in;

   logic                        accept;
   logic                        in_range;
   logic                        do_ins;
   logic                        fire;
   logic                        hit;
   logic                        inserted;
   logic                        div_idle;
   logic                        div_start;
   ptk_pkg::ptk_totals_type     div_totals;

   logic [KC_W-1:0] k_ext, effk, base_ext, fill_ext, n_ins, n_chk, newlen;

   logic signed [ptk_pkg::SCORE_W-1:0] new_score;
   logic [CH_W-1:0]                    new_chan;
   logic [CMP_W-1:0]                   label_cmp;

   logic [MAX_K-1:0] beats, match, avail, occ, chk;
   logic signed [ptk_pkg::SCORE_W-1:0] cell_score [MAX_K];
   logic [CH_W-1:0]                    cell_chan  [MAX_K];

   assign csr_ready = 1'b1;

   always_comb begin
      k_in       = k_ff;
      ign_en_in  = ign_en_ff;
      ign_val_in = ign_val_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ptk_pkg::CSR_K_BEST:        k_in       = csr_wdata[ptk_pkg::KREG_W-1:0];
            ptk_pkg::CSR_IGNORE_ENABLE: ign_en_in  = csr_wdata[0];
            ptk_pkg::CSR_IGNORE_VALUE:  ign_val_in = csr_wdata[ptk_pkg::LABEL_W-1:0];
            default: ;
         endcase
      end
   end

   // k of zero acts as one, above MAX_K acts as MAX_K
   assign k_ext = KC_W'(k_ff);
   assign effk  = (k_ext == '0) ? KC_W'(1) :
                  ((k_ext > KC_W'(MAX_K)) ? KC_W'(MAX_K) : k_ext);

   // finish stage waits only when a frame result is still in flight
   assign fire      = pend_ff && !(pend_last_ff && !div_idle);
   assign req_stall = pend_ff && !fire;
   assign accept    = req_valid && !req_stall;
   assign in_range  = (chan_cnt_ff < CNT_W'(MAX_CHANNELS));
   assign do_ins    = accept && in_range;

   assign new_score = req_data.score;
   assign new_chan  = chan_cnt_ff[CH_W-1:0];
   assign label_cmp = CMP_W'(pend_label_ff);

   // the finishing pixel's list is dead for insertion but still read for the hit
   assign base_ext = pend_ff ? '0 : KC_W'(fill_ff);
   assign fill_ext = KC_W'(fill_ff);
   assign n_ins    = (base_ext < effk) ? base_ext : effk;
   assign n_chk    = (fill_ext < effk) ? fill_ext : effk;
   assign newlen   = (n_ins < effk) ? n_ins + KC_W'(1) : effk;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_K; gi++) begin : g_cell
         ptk_pkg::ptk_cell_ctl_type          ctl;
         logic                               up_beats;
         logic signed [ptk_pkg::SCORE_W-1:0] up_score;
         logic [CH_W-1:0]                    up_chan;

         assign avail[gi] = (KC_W'(gi) < effk);
         assign occ[gi]   = (KC_W'(gi) < n_ins);
         assign chk[gi]   = (KC_W'(gi) < n_chk);
         assign ctl.ins   = do_ins;
         assign ctl.occ   = occ[gi];
         assign ctl.avail = avail[gi];

         if (gi == 0) begin : g_head
            assign up_beats = 1'b0;
            assign up_score = '0;
            assign up_chan  = '0;
         end else begin : g_link
            assign up_beats = beats[gi-1];
            assign up_score = cell_score[gi-1];
            assign up_chan  = cell_chan[gi-1];
         end

         ptk_cell #(
            .CH_W  (CH_W),
            .CMP_W (CMP_W)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .new_score (new_score),
            .new_chan  (new_chan),
            .up_beats  (up_beats),
            .up_score  (up_score),
            .up_chan   (up_chan),
            .label     (label_cmp),
            .beats     (beats[gi]),
            .score     (cell_score[gi]),
            .chan      (cell_chan[gi]),
            .match     (match[gi])
         );
      end
   endgenerate

   assign inserted = |(beats & avail);
   assign hit      = |(match & chk);

   always_comb begin
      fill_in       = fill_ff;
      chan_cnt_in   = chan_cnt_ff;
      pend_in       = fire ? 1'b0 : pend_ff;
      pend_last_in  = pend_last_ff;
      pend_skip_in  = pend_skip_ff;
      pend_label_in = pend_label_ff;

      if (do_ins) begin
         fill_in = inserted ? FILL_W'(newlen) : FILL_W'(n_ins);
      end else if (fire) begin
         fill_in = '0;
      end

      if (accept) begin
         if (req_data.last_channel) begin
            chan_cnt_in   = '0;
            pend_in       = 1'b1;
            pend_last_in  = req_data.last_pixel;
            pend_skip_in  = ign_en_ff && (req_data.true_label == ign_val_ff);
            pend_label_in = req_data.true_label;
         end else if (in_range) begin
            chan_cnt_in = chan_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      div_totals.hits   = hit_ff;
      div_totals.pixels = pix_ff;
      div_totals.skips  = skip_ff;
      if (pend_skip_ff) begin
         div_totals.skips = ptk_pkg::sat_inc(skip_ff);
      end else begin
         div_totals.pixels = ptk_pkg::sat_inc(pix_ff);
         if (hit) div_totals.hits = ptk_pkg::sat_inc(hit_ff);
      end

      div_start = fire && pend_last_ff;
      hit_in    = hit_ff;
      pix_in    = pix_ff;
      skip_in   = skip_ff;
      if (fire) begin
         if (pend_last_ff) begin
            hit_in  = '0;
            pix_in  = '0;
            skip_in = '0;
         end else begin
            hit_in  = div_totals.hits;
            pix_in  = div_totals.pixels;
            skip_in = div_totals.skips;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff        <= ptk_pkg::K_BEST_RESET;
         ign_en_ff   <= 1'b0;
         ign_val_ff  <= ptk_pkg::IGNORE_VALUE_RESET;
         fill_ff     <= '0;
         chan_cnt_ff <= '0;
         pend_ff     <= 1'b0;
         hit_ff      <= '0;
         pix_ff      <= '0;
         skip_ff     <= '0;
      end else begin
         k_ff        <= k_in;
         ign_en_ff   <= ign_en_in;
         ign_val_ff  <= ign_val_in;
         fill_ff     <= fill_in;
         chan_cnt_ff <= chan_cnt_in;
         pend_ff     <= pend_in;
         hit_ff      <= hit_in;
         pix_ff      <= pix_in;
         skip_ff     <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff  <= pend_last_in;
      pend_skip_ff  <= pend_skip_in;
      pend_label_ff <= pend_label_in;
   end

   ptk_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .totals    (div_totals),
      .idle      (div_idle),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_K))
      else $error("list fill above MAX_K");

   a_pixel_close: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last_channel) |=> (pend_ff && (chan_cnt_ff == '0)))
      else $error("pixel end did not open finish stage");

   a_frame_launch: assert property (@(posedge clock) disable iff (reset)
      (fire && pend_last_ff) |=> !div_idle)
      else $error("frame end did not start divider");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (pend_ff && pend_last_ff && !div_idle))
      else $error("input stalled without a pending frame end");

endmodule

`default_nettype wire

// ----- sv/ptk_cell.sv -----
// one slot of the sorted best-score chain: holds a score and its channel
// depends on ptk_pkg; instantiated by per_pixel_topk_accuracy_top
`default_nettype none

module ptk_cell #(
   parameter int CH_W  = 8,
   parameter int CMP_W = 8
) (
   input  wire                                  clock,
   input  wire ptk_pkg::ptk_cell_ctl_type       ctl,
   input  wire logic signed [ptk_pkg::SCORE_W-1:0] new_score,
   input  wire logic [CH_W-1:0]                 new_chan,
   input  wire logic                            up_beats,
   input  wire logic signed [ptk_pkg::SCORE_W-1:0] up_score,
   input  wire logic [CH_W-1:0]                 up_chan,
   input  wire logic [CMP_W-1:0]                label,
   output logic                                 beats,
   output logic signed [ptk_pkg::SCORE_W-1:0]   score,
   output logic [CH_W-1:0]                      chan,
   output logic                                 match
);

   logic signed [ptk_pkg::SCORE_W-1:0] score_ff, score_in;
   logic [CH_W-1:0]                    chan_ff, chan_in;

   // an empty slot is beaten by anything; ties go to the higher channel
   assign beats = !ctl.occ || (new_score > score_ff) ||
                  ((new_score == score_ff) && (new_chan > chan_ff));

   always_comb begin
      score_in = score_ff;
      chan_in  = chan_ff;
      if (ctl.ins && ctl.avail) begin
         if (up_beats) begin
            // new score lands above us, shift the neighbor down
            score_in = up_score;
            chan_in  = up_chan;
         end else if (beats) begin
            score_in = new_score;
            chan_in  = new_chan;
         end
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      chan_ff  <= chan_in;
   end

   assign score = score_ff;
   assign chan  = chan_ff;
   assign match = (CMP_W'(chan_ff) == label);

endmodule

`default_nettype wire

// ----- sv/ptk_div.sv -----
// frame result unit: restoring divider for hits/pixels in q1.16, holds the result
// depends on ptk_pkg; instantiated by per_pixel_topk_accuracy_top
`default_nettype none

module ptk_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire ptk_pkg::ptk_totals_type totals,
   output logic                         idle,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output ptk_pkg::rsp_type             rsp_data
);

   localparam int STEP_W = $clog2(ptk_pkg::ACC_W);
   localparam int TW     = ptk_pkg::TOTAL_W;

   typedef enum logic [2:0] {
      DIV_IDLE = 3'b001,
      DIV_RUN  = 3'b010,
      DIV_HOLD = 3'b100
   } ptk_div_state_type;

   ptk_div_state_type       state_ff, state_in;
   logic [STEP_W-1:0]       cnt_ff, cnt_in;
   logic [TW-1:0]           rem_ff, rem_in;
   logic [ptk_pkg::ACC_W-1:0] quo_ff, quo_in;
   ptk_pkg::ptk_totals_type tot_ff, tot_in;
   logic                    empty_ff, empty_in;

   logic [TW:0] trial;
   logic [TW:0] diff;
   logic        ge;

   // first step tests the integer bit, later steps shift the remainder
   assign trial = (cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign diff  = trial - {1'b0, tot_ff.pixels};
   assign ge    = (trial >= {1'b0, tot_ff.pixels});

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      tot_in   = tot_ff;
      empty_in = empty_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               tot_in   = totals;
               rem_in   = totals.hits;
               quo_in   = '0;
               cnt_in   = '0;
               empty_in = (totals.pixels == '0);
               state_in = (totals.pixels == '0) ? DIV_HOLD : DIV_RUN;
            end
         end
         DIV_RUN: begin
            rem_in = ge ? diff[TW-1:0] : trial[TW-1:0];
            quo_in = {quo_ff[ptk_pkg::ACC_W-2:0], ge};
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(ptk_pkg::ACC_W - 1)) state_in = DIV_HOLD;
         end
         DIV_HOLD: begin
            if (!rsp_stall) state_in = DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      tot_ff   <= tot_in;
      empty_ff <= empty_in;
   end

   assign idle      = (state_ff == DIV_IDLE);
   assign rsp_valid = (state_ff == DIV_HOLD);

   always_comb begin
      rsp_data.hits           = tot_ff.hits;
      rsp_data.counted_pixels = tot_ff.pixels;
      rsp_data.skipped_pixels = tot_ff.skips;
      rsp_data.accuracy_q16   = quo_ff;
      rsp_data.empty_frame    = empty_ff;
   end

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.empty_frame) |-> (rsp_data.accuracy_q16 == '0))
      else $error("empty frame with nonzero accuracy");

   a_hits_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hits <= rsp_data.counted_pixels))
      else $error("hits exceed counted pixels");

endmodule

`default_nettype wire
